// ===== rtl/core/msort_pkg.sv =====
`timescale 1ns / 1ps

package msort_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SORT,
        S_FETCH,
        S_SHOW
    } core_state_t;

    typedef enum logic [1:0] {
        E_IDLE,
        E_RUN,
        E_READ,
        E_WRITE
    } eng_state_t;

    // merge engine status toward the core
    typedef struct packed {
        logic busy;
        logic done;     // one-cycle pulse, sorted set ready
        logic src_sel;  // 0: data buffer holds the current source / result
    } eng_status_t;

endpackage

// ===== rtl/core/msort_ram.sv =====
`timescale 1ns / 1ps

module msort_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int WIDTH  = 32
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/core/msort_merge.sv =====
`timescale 1ns / 1ps

module msort_merge
    import msort_pkg::*;
#(
    parameter int ADDR_W = 6,
    parameter int CNT_W  = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [CNT_W-1:0]  n,
    input  logic [DATA_W-1:0] rd_data_a,
    input  logic [DATA_W-1:0] rd_data_b,
    output logic [ADDR_W-1:0] rd_addr_a,
    output logic [ADDR_W-1:0] rd_addr_b,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [DATA_W-1:0] wr_data,
    output eng_status_t       stat
);

    localparam int SUM_W = CNT_W + 1;

    eng_state_t state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] width_reg, width_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             src_sel_reg, src_sel_next;
    logic             done_reg, done_next;

    logic [SUM_W-1:0] w2_sum, mid_sum, hi_sum, n_ext;
    logic             take_left;
    logic [CNT_W-1:0] k_inc;

    assign n_ext   = {1'b0, n_reg};
    assign w2_sum  = {1'b0, width_reg} << 1;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, width_reg};
    assign hi_sum  = {1'b0, lo_reg} + w2_sum;
    assign k_inc   = k_reg + CNT_W'(1);

    // the shared compare unit; left run wins ties
    assign take_left = (i_reg < mid_reg) &&
                       ((j_reg >= hi_reg) || ($signed(rd_data_a) <= $signed(rd_data_b)));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            E_IDLE: begin
                if (start) begin
                    state_next = (n <= CNT_W'(1)) ? E_IDLE : E_RUN;
                end
            end
            E_RUN:   state_next = E_READ;
            E_READ:  state_next = E_WRITE;
            E_WRITE: begin
                if (k_inc == hi_reg) begin
                    if (hi_reg == n_reg && w2_sum >= n_ext) begin
                        state_next = E_IDLE;
                    end else begin
                        state_next = E_RUN;
                    end
                end else begin
                    state_next = E_READ;
                end
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_comb begin
        rd_addr_a    = i_reg[ADDR_W-1:0];
        rd_addr_b    = j_reg[ADDR_W-1:0];
        wr_en        = (state_reg == E_WRITE);
        wr_addr      = k_reg[ADDR_W-1:0];
        wr_data      = take_left ? rd_data_a : rd_data_b;
        stat.busy    = (state_reg != E_IDLE);
        stat.done    = done_reg;
        stat.src_sel = src_sel_reg;
    end

    always_comb begin
        n_next       = n_reg;
        width_next   = width_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        src_sel_next = src_sel_reg;
        done_next    = 1'b0;
        case (state_reg)
            E_IDLE: begin
                if (start) begin
                    n_next       = n;
                    width_next   = CNT_W'(1);
                    lo_next      = '0;
                    src_sel_next = 1'b0;
                    done_next    = (n <= CNT_W'(1));
                end
            end
            E_RUN: begin
                mid_next = (mid_sum > n_ext) ? n_reg : mid_sum[CNT_W-1:0];
                hi_next  = (hi_sum > n_ext) ? n_reg : hi_sum[CNT_W-1:0];
                i_next   = lo_reg;
                j_next   = (mid_sum > n_ext) ? n_reg : mid_sum[CNT_W-1:0];
                k_next   = lo_reg;
            end
            E_WRITE: begin
                k_next = k_inc;
                if (take_left) begin
                    i_next = i_reg + CNT_W'(1);
                end else begin
                    j_next = j_reg + CNT_W'(1);
                end
                if (k_inc == hi_reg) begin
                    if (hi_reg == n_reg) begin
                        // pass over: swap buffers, double run width
                        lo_next      = '0;
                        width_next   = w2_sum[CNT_W-1:0];
                        src_sel_next = ~src_sel_reg;
                        done_next    = (w2_sum >= n_ext);
                    end else begin
                        lo_next = hi_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            done_reg    <= 1'b0;
            src_sel_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            src_sel_reg <= src_sel_next;
        end
        n_reg     <= n_next;
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
    end

endmodule

// ===== rtl/core/merge_sorter_core.sv =====
`timescale 1ns / 1ps

// Collects up to MAX_ITEMS signed 32-bit items into a buffer, one per cycle, until an
// item with tlast arrives (the item that fills the buffer also closes the set), then
// sorts the set ascending with a stable bottom-up merge sort and streams it out with
// tlast on the final item. Sorting uses one compare unit over two ping-pong RAMs
// with registered reads, in ceil(log2 N) passes for N items. Each output item is
// fetched from RAM, then presented.
// s_tready is low from the closing item until the last sorted item is taken.
module merge_sorter_core
    import msort_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // last_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast    // last_out
);

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

    core_state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] emit_reg, emit_next;

    logic              in_fire, out_fire, closing, eng_start;
    logic [CNT_W-1:0]  fill_inc;
    eng_status_t       stat;
    logic [ADDR_W-1:0] eng_rd_a, eng_rd_b, eng_waddr, emit_addr;
    logic              eng_we;
    logic [DATA_W-1:0] eng_wdata, eng_rdata_a, eng_rdata_b;

    logic              dat_we, scr_we;
    logic [ADDR_W-1:0] dat_waddr, dat_raddr_a, scr_raddr_a;
    logic [DATA_W-1:0] dat_wdata, dat_rdata_a, dat_rdata_b, scr_rdata_a, scr_rdata_b;

    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;
    assign fill_inc  = fill_reg + CNT_W'(1);
    assign closing   = s_tlast || (fill_inc == CNT_W'(MAX_ITEMS));
    assign emit_addr = emit_reg[ADDR_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD: begin
                if (in_fire && closing) begin
                    state_next = S_SORT;
                end
            end
            S_SORT: begin
                if (stat.done) begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: state_next = S_SHOW;
            S_SHOW: begin
                if (out_fire) begin
                    state_next = m_tlast ? S_LOAD : S_FETCH;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == S_LOAD);
        m_tvalid  = (state_reg == S_SHOW);
        m_tdata   = stat.src_sel ? scr_rdata_a : dat_rdata_a;
        m_tlast   = (emit_reg == n_reg - CNT_W'(1));
        eng_start = in_fire && closing;
    end

    always_comb begin
        fill_next = fill_reg;
        n_next    = n_reg;
        emit_next = emit_reg;
        if (in_fire) begin
            fill_next = closing ? '0 : fill_inc;
            if (closing) begin
                n_next = fill_inc;
            end
        end
        if (stat.done) begin
            emit_next = '0;
        end else if (out_fire) begin
            emit_next = emit_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
        n_reg    <= n_next;
        emit_reg <= emit_next;
    end

    // RAM port steering: loader writes data side; emitter reads both outside sorting
    always_comb begin
        dat_we      = in_fire || (eng_we && stat.src_sel);
        dat_waddr   = in_fire ? fill_reg[ADDR_W-1:0] : eng_waddr;
        dat_wdata   = in_fire ? s_tdata : eng_wdata;
        scr_we      = eng_we && !stat.src_sel;
        dat_raddr_a = (state_reg == S_SORT) ? eng_rd_a : emit_addr;
        scr_raddr_a = (state_reg == S_SORT) ? eng_rd_a : emit_addr;
        eng_rdata_a = stat.src_sel ? scr_rdata_a : dat_rdata_a;
        eng_rdata_b = stat.src_sel ? scr_rdata_b : dat_rdata_b;
    end

    msort_ram #(
        .DEPTH  (MAX_ITEMS),
        .ADDR_W (ADDR_W),
        .WIDTH  (DATA_W)
    ) u_data_ram (
        .aclk    (aclk),
        .we      (dat_we),
        .waddr   (dat_waddr),
        .wdata   (dat_wdata),
        .raddr_a (dat_raddr_a),
        .raddr_b (eng_rd_b),
        .rdata_a (dat_rdata_a),
        .rdata_b (dat_rdata_b)
    );

    msort_ram #(
        .DEPTH  (MAX_ITEMS),
        .ADDR_W (ADDR_W),
        .WIDTH  (DATA_W)
    ) u_scratch_ram (
        .aclk    (aclk),
        .we      (scr_we),
        .waddr   (eng_waddr),
        .wdata   (eng_wdata),
        .raddr_a (scr_raddr_a),
        .raddr_b (eng_rd_b),
        .rdata_a (scr_rdata_a),
        .rdata_b (scr_rdata_b)
    );

    msort_merge #(
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (eng_start),
        .n         (fill_inc),
        .rd_data_a (eng_rdata_a),
        .rd_data_b (eng_rdata_b),
        .rd_addr_a (eng_rd_a),
        .rd_addr_b (eng_rd_b),
        .wr_en     (eng_we),
        .wr_addr   (eng_waddr),
        .wr_data   (eng_wdata),
        .stat      (stat)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output active together");

    a_done_in_sort: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> (state_reg == S_SORT))
        else $error("merge done outside of sort phase");

    a_idle_engine: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOAD) |-> !stat.busy)
        else $error("merge engine busy while loading");

    a_close_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after closing item");

    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("input not reopened after final sorted item");

endmodule

// ===== tb/merge_sorter_core_tb.sv =====
`timescale 1ns / 1ps

module merge_sorter_core_tb;
    import msort_pkg::*;

    localparam int SET_CAP     = MAX_ITEMS_DEF;
    localparam int RANDOM_ITEMS = 380;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int TAIL_CYCLES  = 40;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } sorted_item_t;

    typedef struct {
        logic [31:0] value;
        logic        last;
        logic        typed;   // expected item written in the row itself
        logic [31:0] want;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [31:0] value
    logic        s_tlast  = 1'b0;  // last_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [31:0] sorted_value
    logic        m_tlast;          // last_out

    logic signed [31:0] open_set [$];     // values of the set being loaded
    sorted_item_t       sorted_due [$];   // sorted items not yet seen on the output
    int                 mismatches = 0;
    int                 cycles = 0;
    bit                 src_calm = 1'b0;

    // Singletons with typed results first, so the open set is empty for them.
    stim_row_t directed_rows [0:16] = '{
        '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h8000_0000, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFB, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
        '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0003, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0000, 1'b1, 1'b0, 32'h0}
    };

    merge_sorter_core #(
        .MAX_ITEMS(SET_CAP)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2: return 32'($signed($urandom_range(0, 8)) - 4);  // many ties
            default: return $urandom();
        endcase
    endfunction

    // Adds one value to the open set; when the set closes (last or full),
    // queues its values in stable ascending signed order.
    task automatic absorb_value(input logic [31:0] v, input logic l);
        logic signed [31:0] ordered [$];
        logic signed [31:0] key;
        int i;
        int j;
        open_set.push_back(v);
        if (!l && open_set.size() < SET_CAP) begin
            return;
        end
        ordered = open_set;
        // insertion sort keeps equal values in arrival order
        for (i = 1; i < ordered.size(); i++) begin
            key = ordered[i];
            j = i - 1;
            while (j >= 0 && ordered[j] > key) begin
                ordered[j + 1] = ordered[j];
                j--;
            end
            ordered[j + 1] = key;
        end
        for (i = 0; i < ordered.size(); i++) begin
            sorted_due.push_back('{ordered[i], i == ordered.size() - 1});
        end
        open_set.delete();
    endtask

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input logic [31:0] v, input logic l);
        int gap;
        gap = idle_len(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            s_tlast  <= 1'($urandom());
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Output stalls: bursts of ready, with stall stretches between them.
    initial begin
        int stall;
        int run;
        @(posedge aclk);
        forever begin
            stall = ($urandom_range(0, 5) == 0) ? 0 : idle_len(1'b0);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 6);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        sorted_item_t want_item;
        if (aresetn && m_tvalid && m_tready) begin
            if (sorted_due.size() == 0) begin
                $display("%0t: unexpected item, got value %h last %b", $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want_item = sorted_due.pop_front();
                if (m_tdata !== want_item.value) begin
                    $display("%0t: sorted_value mismatch, expected %h got %h",
                             $time, want_item.value, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== want_item.last) begin
                    $display("%0t: last_out mismatch, expected %b got %b",
                             $time, want_item.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int sent;
        int set_len;
        int r;
        int k;
        bit close_flag;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[n]) begin
            send_item(directed_rows[n].value, directed_rows[n].last);
            if (directed_rows[n].typed) begin
                sorted_due.push_back('{directed_rows[n].want, 1'b1});
            end else begin
                absorb_value(directed_rows[n].value, directed_rows[n].last);
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            src_calm   = ($urandom_range(0, 4) == 0);
            close_flag = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 65) begin
                set_len = $urandom_range(1, 12);
            end else if (r < 85) begin
                set_len = $urandom_range(13, SET_CAP - 1);
            end else begin
                // full set; mostly closed by the fill alone
                set_len    = SET_CAP;
                close_flag = (r >= 95);
            end
            if (set_len > RANDOM_ITEMS - sent) begin
                // trim the final set to the item budget
                set_len    = RANDOM_ITEMS - sent;
                close_flag = 1'b1;
            end
            for (k = 0; k < set_len; k++) begin
                logic [31:0] v;
                logic        l;
                v = pick_value();
                l = (k == set_len - 1) ? close_flag : 1'b0;
                send_item(v, l);
                absorb_value(v, l);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (sorted_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
